### rtl/lbprs_pkg.sv
// Shared types and constants for the LED blink pattern register slave.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lbprs_pkg;

    typedef enum logic [1:0] {
        MODE_TICK       = 2'd0,
        MODE_ADDR_START = 2'd1,
        MODE_WRITE      = 2'd2,
        MODE_READ       = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t       mode;
        logic [7:0]  data_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        duty_load;
        logic [7:0]  duty_value;
    } out_item_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;     // latch the accepted transaction
        logic exec;        // perform a single-cycle event
        logic scan_start;  // begin search from position plus one
        logic scan_step;   // advance the search by one entry
        logic scan_done;   // commit the found position and duty
        logic scan_sel;    // table read index comes from the search
        logic push;        // move the result into the output register
    } lbprs_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic scan_needed; // tick with zero count
        logic scan_stop;   // search reached a nonzero entry or the end
        logic out_free;    // output register can take a result
    } lbprs_status_t;

    localparam logic [7:0] VERSION_ADDR  = 8'hC0;
    localparam logic [7:0] VERSION_CODE  = 8'h02;
    localparam logic [7:0] ROM_BASE      = 8'hF0;
    localparam logic [7:0] PATTERN_BASE  = 8'h02;
    localparam logic [7:0] ADDR_ENABLE   = 8'h00;
    localparam logic [7:0] ADDR_PWM      = 8'h01;
    localparam logic [7:0] PWM_RESET     = 8'd199;
    localparam logic [7:0] ENTRY0_RESET  = 8'd1;
    localparam logic [7:0] ENTRY1_RESET  = 8'd20;

    function automatic logic [7:0] id_rom(input logic [3:0] idx);
        logic [7:0] v;
        case (idx)
            4'd0:    v = 8'h50;
            4'd1:    v = 8'h49;
            4'd2:    v = 8'h43;
            4'd3:    v = 8'h5F;
            4'd4:    v = 8'h4C;
            4'd5:    v = 8'h49;
            4'd6:    v = 8'h47;
            4'd7:    v = 8'h48;
            4'd8:    v = 8'h54;
            4'd9:    v = 8'h20;
            4'd10:   v = 8'h76;
            4'd11:   v = 8'h32;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

### rtl/lbprs_ctrl.sv
// Controller state machine for the LED blink pattern register slave.
// Depends on lbprs_pkg for the command and status structs.
`timescale 1ns / 1ps

module lbprs_ctrl
    import lbprs_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  lbprs_status_t status,
    output lbprs_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DECODE = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (status.scan_needed) begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end else begin
                    cmd.exec   = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_SCAN: begin
                cmd.scan_sel = 1'b1;
                if (status.scan_stop) begin
                    cmd.scan_done = 1'b1;
                    state_next    = ST_FINISH;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/lbprs_datapath.sv
// Datapath: register file, pattern table, sequencer counters and output register.
// Depends on lbprs_pkg for payload types, constants and the ID ROM.
`timescale 1ns / 1ps

module lbprs_datapath
    import lbprs_pkg::*;
#(
    parameter int PATTERN_ENTRIES = 10
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  in_item_t      s_data,
    input  lbprs_cmd_t    cmd,
    output lbprs_status_t status,
    output logic          m_valid,
    input  logic          m_ready,
    output out_item_t     m_data
);

    localparam int POS_W  = (PATTERN_ENTRIES > 1) ? $clog2(PATTERN_ENTRIES) : 1;
    localparam int SCAN_W = POS_W + 1;
    localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(PATTERN_ENTRIES - 1);
    localparam logic [SCAN_W-1:0] SCAN_END  = SCAN_W'(PATTERN_ENTRIES);
    localparam logic [8:0]        TBL_SPAN9 = 9'(PATTERN_ENTRIES);

    in_item_t           item_reg;
    logic [7:0]         ptr_reg, ptr_next;
    logic [7:0]         cnt_reg, cnt_next;
    logic [7:0]         enable_reg, enable_next;
    logic [7:0]         pwm_reg, pwm_next;
    logic [7:0]         table_reg [PATTERN_ENTRIES];
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [7:0]         ticks_reg, ticks_next;
    logic [SCAN_W-1:0]  scan_reg, scan_next;
    out_item_t          res_reg, res_next;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_data_reg;

    logic [7:0]         wr_addr, wr_off;
    logic               wr_tbl;
    logic [8:0]         rd_addr, rd_off;
    logic               rd_tbl;
    logic [7:0]         rd_val;
    logic [POS_W-1:0]   tbl_idx;
    logic [7:0]         tbl_entry;
    logic               scan_end;
    logic [POS_W-1:0]   final_pos;
    logic [7:0]         final_entry;

    // Write address is pointer plus count minus one, 8-bit wrap.
    assign wr_addr = ptr_reg + cnt_reg - 8'd1;
    assign wr_off  = wr_addr - PATTERN_BASE;
    assign wr_tbl  = (wr_addr >= PATTERN_BASE) && (wr_off < 8'(PATTERN_ENTRIES));

    // Read address has no wrap.
    assign rd_addr = {1'b0, ptr_reg} + {1'b0, cnt_reg};
    assign rd_off  = rd_addr - {1'b0, PATTERN_BASE};
    assign rd_tbl  = (rd_addr >= {1'b0, PATTERN_BASE}) && (rd_off < TBL_SPAN9);

    assign tbl_idx   = cmd.scan_sel ? scan_reg[POS_W-1:0] : rd_off[POS_W-1:0];
    assign tbl_entry = table_reg[tbl_idx];

    always_comb begin
        if (rd_addr == {1'b0, ADDR_ENABLE}) begin
            rd_val = enable_reg;
        end else if (rd_addr == {1'b0, ADDR_PWM}) begin
            rd_val = pwm_reg;
        end else if (rd_tbl) begin
            rd_val = tbl_entry;
        end else if (rd_addr == {1'b0, VERSION_ADDR}) begin
            rd_val = VERSION_CODE;
        end else if (rd_addr[8:4] == {1'b0, ROM_BASE[7:4]}) begin
            rd_val = id_rom(rd_addr[3:0]);
        end else begin
            rd_val = 8'h00;
        end
    end

    // Guard the table read when the search has run off the end.
    assign scan_end    = (scan_reg >= SCAN_END);
    assign final_pos   = scan_end ? '0 : scan_reg[POS_W-1:0];
    assign final_entry = scan_end ? table_reg[0] : tbl_entry;

    assign status.scan_needed = (item_reg.mode == MODE_TICK) && (ticks_reg == 8'd0);
    assign status.scan_stop   = scan_end ? 1'b1 : (tbl_entry != 8'd0);
    assign status.out_free    = !m_valid_reg || m_ready;

    always_comb begin
        ptr_next    = ptr_reg;
        cnt_next    = cnt_reg;
        enable_next = enable_reg;
        pwm_next    = pwm_reg;
        pos_next    = pos_reg;
        ticks_next  = ticks_reg;
        scan_next   = scan_reg;
        res_next    = res_reg;

        if (cmd.exec) begin
            res_next = '0;
            case (item_reg.mode)
                MODE_ADDR_START: begin
                    cnt_next = 8'd0;
                end
                MODE_WRITE: begin
                    if (cnt_reg == 8'd0) begin
                        ptr_next = item_reg.data_in;
                    end else if (wr_addr == ADDR_ENABLE) begin
                        enable_next = item_reg.data_in;
                        pos_next    = POS_LAST;
                        ticks_next  = 8'd0;
                    end else if (wr_addr == ADDR_PWM) begin
                        pwm_next = item_reg.data_in;
                    end
                    cnt_next = cnt_reg + 8'd1;
                end
                MODE_READ: begin
                    res_next.read_data = rd_val;
                    cnt_next           = cnt_reg + 8'd1;
                end
                MODE_TICK: begin
                    ticks_next = ticks_reg - 8'd1;
                end
                default: begin
                    res_next = '0;
                end
            endcase
        end

        if (cmd.scan_start) begin
            scan_next = {1'b0, pos_reg} + SCAN_W'(1);
        end
        if (cmd.scan_step) begin
            scan_next = scan_reg + SCAN_W'(1);
        end
        if (cmd.scan_done) begin
            pos_next            = final_pos;
            ticks_next          = final_entry - 8'd1;
            res_next.read_data  = 8'd0;
            res_next.duty_load  = 1'b1;
            res_next.duty_value = (!final_pos[0] && enable_reg != 8'd0) ? pwm_reg : 8'd0;
        end
    end

    always_comb begin
        if (cmd.push) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg     <= 8'd0;
            cnt_reg     <= 8'd0;
            enable_reg  <= 8'd0;
            pwm_reg     <= PWM_RESET;
            pos_reg     <= POS_LAST;
            ticks_reg   <= 8'd0;
            m_valid_reg <= 1'b0;
        end else begin
            ptr_reg     <= ptr_next;
            cnt_reg     <= cnt_next;
            enable_reg  <= enable_next;
            pwm_reg     <= pwm_next;
            pos_reg     <= pos_next;
            ticks_reg   <= ticks_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Pattern durations.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PATTERN_ENTRIES; i++) begin
                table_reg[i] <= (i == 0) ? ENTRY0_RESET :
                                ((i == 1) ? ENTRY1_RESET : 8'd0);
            end
        end else if (cmd.exec && item_reg.mode == MODE_WRITE && cnt_reg != 8'd0
                     && wr_tbl) begin
            table_reg[wr_off[POS_W-1:0]] <= item_reg.data_in;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_data;
        end
        scan_reg <= scan_next;
        res_reg  <= res_next;
        if (cmd.push) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### rtl/led_blink_pattern_register_slave_core.sv
// Top level of the LED blink pattern register slave.
// Depends on lbprs_pkg, lbprs_ctrl and lbprs_datapath.
//
//   Channel   Direction  Payload     Transaction
//   s_        in         in_item_t   s_valid && s_ready
//   m_        out        out_item_t  m_valid && m_ready
//
// Each transaction passes through accept, decode and finish, with the pattern
// search between decode and finish. A tick with a zero count walks the pattern
// table one entry per cycle until it finds a nonzero entry or reaches the end.
// The next item is taken while a result still waits in the output register;
// a stalled output holds the block in finish. Reset is synchronous on aresetn
// low and restores all registers at once except the payload registers.
`timescale 1ns / 1ps

module led_blink_pattern_register_slave_core
    import lbprs_pkg::*;
#(
    parameter int PATTERN_ENTRIES = 10
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    // Command and status between the sequencing control and the datapath.
    lbprs_cmd_t    cmd;
    lbprs_status_t status;

    // Sequence each transaction: decode, optional search, hand off result.
    lbprs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Hold bus registers, pattern table, sequencer state and the result.
    lbprs_datapath #(
        .PATTERN_ENTRIES (PATTERN_ENTRIES)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

### tb/led_blink_pattern_register_slave_core_tb.sv
// Self-checking testbench for the LED blink pattern register slave core.
// Depends on lbprs_pkg and led_blink_pattern_register_slave_core; nothing else.
`timescale 1ns / 1ps

module led_blink_pattern_register_slave_core_tb;
    import lbprs_pkg::*;

    localparam int          PATTERN_ENTRIES = 10;
    localparam int          CYCLE_LIMIT     = 1_000_000;
    localparam int          RANDOM_EVENTS   = 1700;
    // ID ROM contents, first byte in the top bits
    localparam logic [127:0] ID_STRING      = 128'h5049435F_4C494748_54207632_00000000;

    // One queued bus event; settle makes the sender wait for every reply first
    typedef struct {
        in_item_t ev;
        bit       settle;
    } bus_event_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    bus_event_t bus_events[$];
    out_item_t  replies_due[$];
    bit         settle_next;
    int         fail_count;
    int         cycle_count;

    // Shadow copy of the slave registers and the blink sequencer
    logic [7:0] ptr_q;
    logic [7:0] count_q;
    logic [7:0] enable_q;
    logic [7:0] level_q;
    logic [7:0] durations [PATTERN_ENTRIES];
    logic [3:0] position_q;
    logic [7:0] ticks_left;

    // Sender and receiver pacing
    int unsigned tx_gap;
    bit          tx_quiet;
    int unsigned rx_hold;
    bit          rx_quiet;

    led_blink_pattern_register_slave_core #(
        .PATTERN_ENTRIES(PATTERN_ENTRIES)
    ) u_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Register file and sequencer shadow
    // ------------------------------------------------------------------

    task automatic reset_shadow();
        ptr_q      = '0;
        count_q    = '0;
        enable_q   = '0;
        level_q    = PWM_RESET;
        foreach (durations[i]) durations[i] = '0;
        durations[0] = ENTRY0_RESET;
        durations[1] = ENTRY1_RESET;
        position_q = 4'(PATTERN_ENTRIES - 1);
        ticks_left = '0;
    endtask

    // Read address is a 9-bit sum: anything past 0xFF reads as zero
    function automatic logic [7:0] register_at(int unsigned addr);
        if (addr == ADDR_ENABLE)
            return enable_q;
        if (addr == ADDR_PWM)
            return level_q;
        if (addr >= PATTERN_BASE && addr < PATTERN_BASE + PATTERN_ENTRIES)
            return durations[addr - PATTERN_BASE];
        if (addr == VERSION_ADDR)
            return VERSION_CODE;
        if (addr >= ROM_BASE && addr <= 8'hFF)
            return ID_STRING[127 - 8 * (addr - ROM_BASE) -: 8];
        return 8'h00;
    endfunction

    // Advance the shadow by one accepted event and return the reply it produces
    function automatic out_item_t slave_reply(in_item_t ev);
        out_item_t   r;
        logic [7:0]  waddr;
        int unsigned p;
        r = '0;
        case (ev.mode)
            MODE_ADDR_START: begin
                count_q = '0;
            end
            MODE_WRITE: begin
                if (count_q == 0) begin
                    ptr_q = ev.data_in;
                end else begin
                    waddr = ptr_q + count_q - 8'd1;
                    if (waddr == ADDR_ENABLE) begin
                        enable_q   = ev.data_in;
                        position_q = 4'(PATTERN_ENTRIES - 1);
                        ticks_left = '0;
                    end else if (waddr == ADDR_PWM) begin
                        level_q = ev.data_in;
                    end else if (waddr >= PATTERN_BASE
                                 && waddr < PATTERN_BASE + PATTERN_ENTRIES) begin
                        durations[waddr - PATTERN_BASE] = ev.data_in;
                    end
                end
                count_q = count_q + 8'd1;
            end
            MODE_READ: begin
                r.read_data = register_at(int'(ptr_q) + int'(count_q));
                count_q = count_q + 8'd1;
            end
            default: begin
                if (ticks_left == 0) begin
                    // Step past empty entries; run off the end back to entry 0
                    p = position_q + 1;
                    while (p < PATTERN_ENTRIES && durations[p] == 0)
                        p++;
                    if (p >= PATTERN_ENTRIES)
                        p = 0;
                    position_q   = 4'(p);
                    ticks_left   = durations[p] - 8'd1;
                    r.duty_load  = 1'b1;
                    r.duty_value = (p % 2 == 0 && enable_q != 0) ? level_q : 8'h00;
                end else begin
                    ticks_left = ticks_left - 8'd1;
                end
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_event(mode_t m, logic [7:0] d);
        bus_event_t e;
        e.ev.mode    = m;
        e.ev.data_in = d;
        e.settle     = settle_next;
        settle_next  = 1'b0;
        bus_events.push_back(e);
    endtask

    // Mostly short durations so the sequencer wraps often, now and then any byte
    function automatic logic [7:0] pick_duration();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 8'($urandom_range(0, 3));
        if (r < 85)
            return 8'($urandom_range(4, 10));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_pointer();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 8'($urandom_range(0, PATTERN_BASE + PATTERN_ENTRIES - 1));
        if (r < 75)
            return VERSION_ADDR - 8'($urandom_range(0, 1));
        if (r < 85)
            return 8'($urandom_range(ROM_BASE - 1, 8'hFF));
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly back-to-back, often a short pause, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic note_failure(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%t: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------
    // Driver: present queued events, predict each one as it is accepted
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        bus_event_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap  = 0;
        end else if (!s_valid || s_ready) begin
            // Transaction accepted on this edge: s_data still holds its payload
            if (s_valid)
                replies_due.push_back(slave_reply(s_data));
            if ($urandom_range(0, 149) == 0)
                tx_quiet = !tx_quiet;
            if (tx_gap != 0) begin
                tx_gap  = tx_gap - 1;
                s_valid <= 1'b0;
            end else if (bus_events.size() != 0
                         && !(bus_events[0].settle && replies_due.size() != 0)) begin
                nxt     = bus_events.pop_front();
                s_data  <= nxt.ev;
                s_valid <= 1'b1;
                tx_gap  = tx_quiet ? 0 : pick_gap();
            end else begin
                // Drop valid while idle or while waiting for replies to drain
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each reply against the oldest prediction, pace m_ready
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_hold = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (replies_due.size() == 0) begin
                    note_failure($sformatf("unexpected reply rd=%02h load=%0b duty=%02h",
                                           m_data.read_data, m_data.duty_load,
                                           m_data.duty_value));
                end else begin
                    want = replies_due.pop_front();
                    if (m_data.read_data !== want.read_data
                        || m_data.duty_load !== want.duty_load
                        || m_data.duty_value !== want.duty_value)
                        note_failure($sformatf(
                            "reply mismatch: rd %02h/%02h load %0b/%0b duty %02h/%02h (exp/got)",
                            want.read_data, m_data.read_data,
                            want.duty_load, m_data.duty_load,
                            want.duty_value, m_data.duty_value));
                end
            end
            if ($urandom_range(0, 299) == 0)
                rx_quiet = !rx_quiet;
            if (rx_hold != 0) begin
                rx_hold = rx_hold - 1;
                m_ready <= 1'b0;
            end else if (!rx_quiet && $urandom_range(0, 99) < 20) begin
                rx_hold = pick_gap();
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Hard stop in case the block hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("led_blink_pattern_register_slave_core_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of test
    // ------------------------------------------------------------------

    initial begin
        int unsigned r;
        int unsigned len;
        int          target;
        reset_shadow();

        // Reset contents: enable, PWM level, first duration
        queue_event(MODE_ADDR_START, 8'h00);
        queue_event(MODE_READ, 8'h00);
        queue_event(MODE_READ, 8'h00);
        queue_event(MODE_READ, 8'h00);
        // Ticks from reset: wrap to entry 0, then step to entry 1; data is ignored
        queue_event(MODE_TICK, 8'hFF);
        queue_event(MODE_TICK, 8'h00);
        queue_event(MODE_TICK, 8'hFF);
        // Enable with all ones, set level, clear entry 0 so the wrap lands on zero
        queue_event(MODE_ADDR_START, 8'h00);
        queue_event(MODE_WRITE, 8'h00);
        queue_event(MODE_WRITE, 8'hFF);
        queue_event(MODE_WRITE, 8'h05);
        queue_event(MODE_WRITE, 8'h00);
        queue_event(MODE_TICK, 8'h00);
        queue_event(MODE_TICK, 8'h00);
        // Version byte
        queue_event(MODE_ADDR_START, 8'h00);
        queue_event(MODE_WRITE, VERSION_ADDR - 8'd1);
        queue_event(MODE_READ, 8'h00);
        // Top of the ID ROM and the read past 0xFF
        queue_event(MODE_ADDR_START, 8'h00);
        queue_event(MODE_WRITE, 8'hFE);
        queue_event(MODE_READ, 8'h00);
        queue_event(MODE_READ, 8'h00);
        // Write address wraps from 0xFF to the enable register, restarting the pattern
        queue_event(MODE_ADDR_START, 8'h00);
        queue_event(MODE_WRITE, 8'hFF);
        queue_event(MODE_WRITE, 8'hAA);
        queue_event(MODE_WRITE, 8'h01);

        // Long read burst: the read sum reaches 0xFF, then the byte count wraps
        settle_next = 1'b1;
        queue_event(MODE_ADDR_START, 8'h00);
        queue_event(MODE_WRITE, 8'h00);
        repeat (258) queue_event(MODE_READ, 8'h00);

        target = bus_events.size() + RANDOM_EVENTS - 260;
        while (bus_events.size() < target) begin
            if ($urandom_range(0, 99) < 3)
                settle_next = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 30) begin
                // Register write transaction
                queue_event(MODE_ADDR_START, 8'($urandom_range(0, 255)));
                queue_event(MODE_WRITE, pick_pointer());
                len = $urandom_range(0, 4);
                repeat (len)
                    queue_event(MODE_WRITE, $urandom_range(0, 1) ? pick_duration()
                                                                : 8'($urandom_range(0, 255)));
            end else if (r < 45) begin
                // Register read transaction, with or without a new pointer
                queue_event(MODE_ADDR_START, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 3) != 0)
                    queue_event(MODE_WRITE, pick_pointer());
                len = $urandom_range(1, 4);
                repeat (len) queue_event(MODE_READ, 8'($urandom_range(0, 255)));
            end else if (r < 88) begin
                // Timer ticks, now and then a long run to get through big durations
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 260)
                                                   : $urandom_range(1, 12);
                repeat (len) queue_event(MODE_TICK, 8'($urandom_range(0, 255)));
            end else begin
                // Stray events in any order
                len = $urandom_range(1, 3);
                repeat (len)
                    queue_event(mode_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Hold until every event is accepted and every reply has come back
        while (bus_events.size() != 0 || s_valid || replies_due.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (replies_due.size() != 0)
            note_failure($sformatf("%0d replies never arrived", replies_due.size()));

        if (fail_count == 0)
            $display("led_blink_pattern_register_slave_core_tb OK");
        else
            $display("led_blink_pattern_register_slave_core_tb NOT OK");
        $finish;
    end

endmodule
